[rtl/core/user_page_table_leaf_manager_defines.svh]
// ---------------------------------------------------------------------------
// user_page_table_leaf_manager_defines.svh
// Assertion macros shared by the leaf manager RTL.
// ---------------------------------------------------------------------------
`ifndef USER_PAGE_TABLE_LEAF_MANAGER_DEFINES_SVH
`define USER_PAGE_TABLE_LEAF_MANAGER_DEFINES_SVH

// implication checked on every clock, masked while in reset
`define UPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define UPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/uptlm_pkg.sv]
// ---------------------------------------------------------------------------
// uptlm_pkg
// Types and constants for the user page table leaf manager.
// ---------------------------------------------------------------------------
`default_nettype none
package uptlm_pkg;
   localparam logic [1:0] CMD_MAP   = 2'd0;
   localparam logic [1:0] CMD_UNMAP = 2'd1;
   localparam logic [1:0] CMD_PERM  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NONCANON  = 4'd1;
   localparam logic [3:0] ST_MISALIGN  = 4'd2;
   localparam logic [3:0] ST_NULL      = 4'd3;
   localparam logic [3:0] ST_OUTSIDE   = 4'd4;
   localparam logic [3:0] ST_GUARD     = 4'd5;
   localparam logic [3:0] ST_BAD_PERM  = 4'd6;
   localparam logic [3:0] ST_BAD_FRAME = 4'd7;
   localparam logic [3:0] ST_ALIAS     = 4'd8;
   localparam logic [3:0] ST_EXISTS    = 4'd9;
   localparam logic [3:0] ST_USED      = 4'd10;
   localparam logic [3:0] ST_LIMIT     = 4'd11;
   localparam logic [3:0] ST_NOT_FOUND = 4'd12;
   localparam logic [3:0] ST_MISMATCH  = 4'd13;

   localparam logic [2:0] CSR_PHYS_MASK = 3'd0;
   localparam logic [2:0] CSR_PRIV_A    = 3'd1;
   localparam logic [2:0] CSR_PRIV_B    = 3'd2;
   localparam logic [2:0] CSR_PRIV_C    = 3'd3;
   localparam logic [2:0] CSR_PRIV_D    = 3'd4;
   localparam logic [2:0] CSR_WIN_BASE  = 3'd5;
   localparam logic [2:0] CSR_GUARD     = 3'd6;
   localparam logic [2:0] CSR_LIMIT     = 3'd7;

   // x86-64 leaf entry bit positions
   localparam int PTE_P  = 0;
   localparam int PTE_W  = 1;
   localparam int PTE_U  = 2;
   localparam int PTE_A  = 5;
   localparam int PTE_D  = 6;
   localparam int PTE_NX = 63;

   // permission request bits
   localparam int PRM_R = 0;
   localparam int PRM_W = 1;
   localparam int PRM_X = 2;
   localparam int PRM_U = 3;

   typedef struct packed {
      logic [3:0]  status;
      logic [51:0] frame;
      logic [3:0]  perm;
      logic        accessed;
      logic        dirty;
   } rsp_type;

   function automatic logic perms_ok(input logic [3:0] p);
      return p[PRM_R] && p[PRM_U] && !(p[PRM_W] && p[PRM_X]);
   endfunction

   function automatic logic [63:0] make_leaf(input logic [51:0] frame,
                                             input logic [3:0] p,
                                             input logic [63:0] keep);
      logic [63:0] e;
      e = '0;
      e[51:12] = frame[51:12];
      e[PTE_P] = 1'b1;
      e[PTE_U] = 1'b1;
      e[PTE_A] = keep[PTE_A];
      e[PTE_D] = keep[PTE_D];
      e[PTE_W] = p[PRM_W];
      e[PTE_NX] = !p[PRM_X];
      return e;
   endfunction
endpackage
`default_nettype wire

[rtl/core/uptlm_addr_check.sv]
// ---------------------------------------------------------------------------
// uptlm_addr_check
// Registered virtual address checks and leaf slot calculation.
// ---------------------------------------------------------------------------
`default_nettype none
module uptlm_addr_check
   import uptlm_pkg::*;
#(
   parameter int LEAF_ENTRIES = 512,
   parameter int SLOT_W       = 9
) (
   input  wire logic              clock,
   input  wire logic [63:0]       va,
   input  wire logic [46:0]       window_base,
   input  wire logic [46:0]       guard_address,
   output logic [3:0]             status_ff,
   output logic [SLOT_W-1:0]      slot_ff
);
   // window span is one page per leaf entry
   localparam logic [47:0] SPAN = 48'(LEAF_ENTRIES) << 12;

   logic [3:0]        status_in;
   logic [SLOT_W-1:0] slot_in;
   logic [47:0]       win_end;
   logic [47:0]       offs;
   logic              canon;

   always_comb begin
      win_end = {1'b0, window_base} + SPAN;
      offs    = va[47:0] - {1'b0, window_base};
      canon   = va[47] ? (va[63:48] == 16'hFFFF) : (va[63:48] == 16'h0000);
      slot_in = offs[12 +: SLOT_W];
      if (!canon)
         status_in = ST_NONCANON;
      else if (va[11:0] != 12'd0)
         status_in = ST_MISALIGN;
      else if (va[63:12] == 52'd0)
         status_in = ST_NULL;
      else if (va[63:47] != 17'd0 || va[46:0] < window_base
               || {1'b0, va[46:0]} >= win_end)
         status_in = ST_OUTSIDE;
      else if (va[46:0] == guard_address)
         status_in = ST_GUARD;
      else
         status_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end
endmodule
`default_nettype wire

[rtl/core/user_page_table_leaf_manager.sv]
// ---------------------------------------------------------------------------
// user_page_table_leaf_manager
// Leaf page table manager kept in one synchronous memory, with a frame scan.
// ---------------------------------------------------------------------------
// Channel | Direction | Content
// req_    | in        | tdata: cmd, vaddr, frame_address, perm_request
// rsp_    | out       | tdata: status, frame_out, perm_out, accessed_out, dirty_out
// csr_    | in        | write enable, register index, 52-bit data
//
// After reset a clearing pass writes every memory entry. Map checks, reads
// and decides, then scans every entry for the frame, checks use and limit,
// writes back and offers its result; the frame scan reads one entry a cycle.
// Other commands offer it after check, read, decide and write back, an address
// error after check and read. Back in idle the cycle after the result is taken.
// One transaction at a time; a result waiting on rsp_tready stalls the next.
`default_nettype none
`include "user_page_table_leaf_manager_defines.svh"
module user_page_table_leaf_manager
   import uptlm_pkg::*;
#(
   parameter int LEAF_ENTRIES = 512
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd[1:0], vaddr[65:2], frame_address[117:66], perm_request[121:118]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[3:0], frame_out[55:4], perm_out[59:56], accessed_out[60], dirty_out[61]
   output logic [63:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [51:0]  csr_wdata
);
   localparam int SLOT_W = (LEAF_ENTRIES > 1) ? $clog2(LEAF_ENTRIES) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(LEAF_ENTRIES - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_READ  = 4'd3;
   localparam logic [3:0] S_EVAL  = 4'd4;
   localparam logic [3:0] S_SCAN  = 4'd5;
   localparam logic [3:0] S_SDONE = 4'd6;
   localparam logic [3:0] S_RESP  = 4'd7;

   // configuration registers
   logic [51:0] phys_mask_ff, priv_a_ff, priv_b_ff, priv_c_ff, priv_d_ff;
   logic [46:0] win_base_ff, guard_ff;
   logic [9:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_mask_ff <= 52'd4503599627366400;
         priv_a_ff    <= '0;
         priv_b_ff    <= '0;
         priv_c_ff    <= '0;
         priv_d_ff    <= '0;
         win_base_ff  <= 47'd2097152;
         guard_ff     <= 47'd4190208;
         limit_ff     <= 10'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHYS_MASK: phys_mask_ff <= csr_wdata;
            CSR_PRIV_A:    priv_a_ff    <= csr_wdata;
            CSR_PRIV_B:    priv_b_ff    <= csr_wdata;
            CSR_PRIV_C:    priv_c_ff    <= csr_wdata;
            CSR_PRIV_D:    priv_d_ff    <= csr_wdata;
            CSR_WIN_BASE:  win_base_ff  <= csr_wdata[46:0];
            CSR_GUARD:     guard_ff     <= csr_wdata[46:0];
            CSR_LIMIT:     limit_ff     <= csr_wdata[9:0];
            default:       ;
         endcase
      end
   end

   // request capture
   logic [1:0]  cmd_ff;
   logic [63:0] va_ff;
   logic [51:0] frame_ff;
   logic [3:0]  perm_ff;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [9:0]        live_ff, live_in;
   logic              used_ff, used_in;
   rsp_type           rsp_ff, rsp_in;

   logic [3:0]        addr_status;
   logic [SLOT_W-1:0] slot;

   uptlm_addr_check #(.LEAF_ENTRIES(LEAF_ENTRIES), .SLOT_W(SLOT_W)) u_check (
      .clock         (clock),
      .va            (va_ff),
      .window_base   (win_base_ff),
      .guard_address (guard_ff),
      .status_ff     (addr_status),
      .slot_ff       (slot)
   );

   // leaf table memory
   logic [63:0]       mem [LEAF_ENTRIES];
   logic [63:0]       rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [63:0]       wr_data;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   logic frame_ok, alias_hit, scan_hit;
   always_comb begin
      frame_ok  = frame_ff != 52'd0 && frame_ff[11:0] == 12'd0
                  && (frame_ff & ~phys_mask_ff) == 52'd0;
      alias_hit = frame_ff == priv_a_ff || frame_ff == priv_b_ff
                  || frame_ff == priv_c_ff || frame_ff == priv_d_ff;
      scan_hit  = rd_data_ff != 64'd0 && rd_data_ff[51:12] == frame_ff[51:12]
                  && frame_ff[11:0] == 12'd0;
   end

   // control sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      live_in  = live_ff;
      used_in  = used_ff;
      rsp_in   = rsp_ff;
      rd_addr  = slot;
      wr_en    = 1'b0;
      wr_addr  = slot;
      wr_data  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[SLOT_W-1:0];
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == LAST)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid)
               state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = (addr_status == ST_OK) ? S_EVAL : S_RESP;
            rsp_in = '0;
            rsp_in.status = addr_status;
         end
         S_EVAL: begin
            rsp_in = '0;
            state_in = S_RESP;
            unique case (cmd_ff)
               CMD_MAP: begin
                  if (!perms_ok(perm_ff))
                     rsp_in.status = ST_BAD_PERM;
                  else if (!frame_ok)
                     rsp_in.status = ST_BAD_FRAME;
                  else if (alias_hit)
                     rsp_in.status = ST_ALIAS;
                  else if (rd_data_ff != 64'd0)
                     rsp_in.status = ST_EXISTS;
                  else begin
                     idx_in   = '0;
                     used_in  = 1'b0;
                     rd_addr  = '0;
                     state_in = S_SCAN;
                  end
               end
               CMD_UNMAP: begin
                  if (!frame_ok)
                     rsp_in.status = ST_BAD_FRAME;
                  else if (rd_data_ff == 64'd0)
                     rsp_in.status = ST_NOT_FOUND;
                  else if (rd_data_ff[51:12] != frame_ff[51:12])
                     rsp_in.status = ST_MISMATCH;
                  else begin
                     wr_en   = 1'b1;
                     live_in = live_ff - 10'd1;
                  end
               end
               CMD_PERM: begin
                  if (!perms_ok(perm_ff))
                     rsp_in.status = ST_BAD_PERM;
                  else if (rd_data_ff == 64'd0)
                     rsp_in.status = ST_NOT_FOUND;
                  else begin
                     wr_en   = 1'b1;
                     wr_data = make_leaf(rd_data_ff[51:0], perm_ff, rd_data_ff);
                  end
               end
               default: begin
                  if (rd_data_ff == 64'd0)
                     rsp_in.status = ST_NOT_FOUND;
                  else begin
                     rsp_in.frame = {rd_data_ff[51:12], 12'd0};
                     rsp_in.perm  = {1'b1, !rd_data_ff[PTE_NX],
                                     rd_data_ff[PTE_W], 1'b1};
                     rsp_in.accessed = rd_data_ff[PTE_A];
                     rsp_in.dirty    = rd_data_ff[PTE_D];
                  end
               end
            endcase
         end
         S_SCAN: begin
            // read entry idx+1 while entry idx is presented
            rd_addr = SLOT_W'(idx_ff + 1'b1);
            if (idx_ff != '0 && scan_hit)
               used_in = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST)
               state_in = S_SDONE;
         end
         S_SDONE: begin
            // every entry has been compared by now
            state_in = S_RESP;
            if (used_ff)
               rsp_in.status = ST_USED;
            else if (live_ff >= limit_ff)
               rsp_in.status = ST_LIMIT;
            else begin
               wr_en   = 1'b1;
               wr_data = make_leaf(frame_ff, perm_ff, 64'd0);
               live_in = live_ff + 10'd1;
            end
         end
         S_RESP: begin
            if (rsp_tready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // entry 0 is checked on the first scan cycle via the read issued in EVAL
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         live_ff  <= '0;
         used_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         live_ff  <= live_in;
         used_ff  <= (state_ff == S_SCAN && idx_ff == '0) ? scan_hit : used_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      if (state_ff == S_IDLE && req_tvalid) begin
         cmd_ff   <= req_tdata[1:0];
         va_ff    <= req_tdata[65:2];
         frame_ff <= req_tdata[117:66];
         perm_ff  <= req_tdata[121:118];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {2'b00, rsp_ff.dirty, rsp_ff.accessed, rsp_ff.perm,
                        rsp_ff.frame, rsp_ff.status};

   `UPT_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready, "both sides open")
   `UPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
   `UPT_ASSERT_IMP(a_live_bound, clock, reset, 1'b1, live_ff <= 10'(LEAF_ENTRIES), "live count beyond table")
   `UPT_ASSERT_IMP(a_zero_err, clock, reset, rsp_tvalid && rsp_ff.status != ST_OK, rsp_ff.frame == 52'd0 && rsp_ff.perm == 4'd0, "error with payload")
endmodule
`default_nettype wire

[bench/upt_checker.sv]
// ---------------------------------------------------------------------------
// upt_checker
// Watches the request, result and register channels of the leaf manager. It
// keeps its own copy of the leaf table, the live count and the registers,
// works out the result of each request and compares the results field by
// field, oldest first.
// ---------------------------------------------------------------------------
`default_nettype none
module upt_checker
   import uptlm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [51:0]  csr_wdata,
   output int                fail_count,
   output int                pending
);
   localparam int          SLOTS       = 512;
   localparam logic [63:0] WINDOW_SPAN = 64'd512 * 64'd4096;

   // shadow state
   logic [63:0] leaf_shadow [SLOTS];
   logic [9:0]  live_shadow;
   logic [51:0] phys_mask, priv_a, priv_b, priv_c, priv_d;
   logic [46:0] win_base, guard_va;
   logic [9:0]  map_limit;

   rsp_type     expected_rsp_q [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic logic [3:0] va_check_status(input logic [63:0] va);
      logic [63:0] lo;
      lo = {17'd0, win_base};
      if (va[47] ? (va[63:48] != 16'hFFFF) : (va[63:48] != 16'h0000)) return ST_NONCANON;
      if (va[11:0] != 12'd0)                    return ST_MISALIGN;
      if (va < 64'd4096)                        return ST_NULL;
      if (va < lo || va >= lo + WINDOW_SPAN)    return ST_OUTSIDE;
      if (va == {17'd0, guard_va})              return ST_GUARD;
      return ST_OK;
   endfunction

   function automatic logic perm_legal(input logic [3:0] p);
      return p[PRM_R] && p[PRM_U] && !(p[PRM_W] && p[PRM_X]);
   endfunction

   function automatic logic frame_legal(input logic [51:0] f);
      return (f != 52'd0) && (f[11:0] == 12'd0) && ((f & ~phys_mask) == 52'd0);
   endfunction

   function automatic logic [63:0] leaf_entry(input logic [51:0] f, input logic [3:0] p,
                                              input logic [63:0] keep);
      logic [63:0] e;
      e          = {12'd0, f[51:12], 12'd0};
      e[PTE_P]   = 1'b1;
      e[PTE_U]   = 1'b1;
      e[PTE_A]   = keep[PTE_A];
      e[PTE_D]   = keep[PTE_D];
      e[PTE_W]   = p[PRM_W];
      e[PTE_NX]  = ~p[PRM_X];
      return e;
   endfunction

   // works out one result and updates the shadow table
   task automatic predict_leaf_op(input logic [1:0] cmd, input logic [63:0] va,
                                  input logic [51:0] f, input logic [3:0] p);
      rsp_type     r;
      logic [63:0] e;
      logic [63:0] off;
      int          slot;
      logic        used;
      r      = '0;
      slot   = 0;
      r.status = va_check_status(va);
      if (r.status == ST_OK) begin
         off  = va - {17'd0, win_base};
         slot = int'(off[20:12]);
         e    = leaf_shadow[slot];
         case (cmd)
            CMD_MAP: begin
               used = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (leaf_shadow[i] != 64'd0 && leaf_shadow[i][51:12] == f[51:12])
                     used = 1'b1;
               if (!perm_legal(p))                      r.status = ST_BAD_PERM;
               else if (!frame_legal(f))                r.status = ST_BAD_FRAME;
               else if (f == priv_a || f == priv_b ||
                        f == priv_c || f == priv_d)     r.status = ST_ALIAS;
               else if (e != 64'd0)                     r.status = ST_EXISTS;
               else if (used)                           r.status = ST_USED;
               else if (live_shadow >= map_limit)       r.status = ST_LIMIT;
               else begin
                  leaf_shadow[slot] = leaf_entry(f, p, 64'd0);
                  live_shadow       = live_shadow + 10'd1;
               end
            end
            CMD_UNMAP: begin
               if (!frame_legal(f))                     r.status = ST_BAD_FRAME;
               else if (e == 64'd0)                     r.status = ST_NOT_FOUND;
               else if ({12'd0, e[51:12], 12'd0} != {12'd0, f}) r.status = ST_MISMATCH;
               else begin
                  leaf_shadow[slot] = 64'd0;
                  live_shadow       = live_shadow - 10'd1;
               end
            end
            CMD_PERM: begin
               if (!perm_legal(p))                      r.status = ST_BAD_PERM;
               else if (e == 64'd0)                     r.status = ST_NOT_FOUND;
               else leaf_shadow[slot] = leaf_entry(e[51:0], p, e);
            end
            default: begin
               if (e == 64'd0) r.status = ST_NOT_FOUND;
               else begin
                  r.frame          = {e[51:12], 12'd0};
                  r.perm           = '0;
                  r.perm[PRM_R]    = 1'b1;
                  r.perm[PRM_U]    = 1'b1;
                  r.perm[PRM_W]    = e[PTE_W];
                  r.perm[PRM_X]    = ~e[PTE_NX];
                  r.accessed       = e[PTE_A];
                  r.dirty          = e[PTE_D];
               end
            end
         endcase
      end
      expected_rsp_q.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) leaf_shadow[i] = 64'd0;
         live_shadow = '0;
         phys_mask   = 52'hF_FFFF_FFFF_F000;
         priv_a      = '0;
         priv_b      = '0;
         priv_c      = '0;
         priv_d      = '0;
         win_base    = 47'h20_0000;
         guard_va    = 47'h3F_F000;
         map_limit   = 10'd512;
         fail_count  = 0;
         expected_rsp_q.delete();
      end else begin
         // result transaction: compare with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 64'd0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tdata[3:0] != want.status)
                  report_mismatch("status", 64'(rsp_tdata[3:0]), 64'(want.status));
               if (rsp_tdata[55:4] != want.frame)
                  report_mismatch("frame_out", 64'(rsp_tdata[55:4]), 64'(want.frame));
               if (rsp_tdata[59:56] != want.perm)
                  report_mismatch("perm_out", 64'(rsp_tdata[59:56]), 64'(want.perm));
               if (rsp_tdata[60] != want.accessed)
                  report_mismatch("accessed_out", 64'(rsp_tdata[60]), 64'(want.accessed));
               if (rsp_tdata[61] != want.dirty)
                  report_mismatch("dirty_out", 64'(rsp_tdata[61]), 64'(want.dirty));
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_PHYS_MASK: phys_mask = csr_wdata;
               CSR_PRIV_A:    priv_a    = csr_wdata;
               CSR_PRIV_B:    priv_b    = csr_wdata;
               CSR_PRIV_C:    priv_c    = csr_wdata;
               CSR_PRIV_D:    priv_d    = csr_wdata;
               CSR_WIN_BASE:  win_base  = csr_wdata[46:0];
               CSR_GUARD:     guard_va  = csr_wdata[46:0];
               default:       map_limit = csr_wdata[9:0];
            endcase
         end
         // request transaction
         if (req_tvalid && req_tready)
            predict_leaf_op(req_tdata[1:0], req_tdata[65:2], req_tdata[117:66],
                            req_tdata[121:118]);
      end
      pending = expected_rsp_q.size();
   end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the leaf manager: a directed set of requests, then phases of
// random requests under several register settings, with random idling on
// both channels. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top
   import uptlm_pkg::*;
();

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // cmd[1:0], vaddr[65:2], frame_address[117:66], perm_request[121:118]
   logic [127:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // status[3:0], frame_out[55:4], perm_out[59:56], accessed_out[60], dirty_out[61]
   logic [63:0]  rsp_tdata;
   logic         csr_we     = 1'b0;
   logic [2:0]   csr_index  = '0;
   logic [51:0]  csr_wdata  = '0;
   int           fail_count;
   int           pending;

   bit           calm       = 1'b0;   // no idling while set
   logic [63:0]  cur_base   = 64'h20_0000;
   logic [51:0]  cur_mask   = 52'hF_FFFF_FFFF_F000;

   user_page_table_leaf_manager u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   upt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(posedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);

   // hang guard
   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // one request transaction; valid stays high unless an idle gap is taken
   task automatic send_req(input logic [1:0] cmd, input logic [63:0] va,
                           input logic [51:0] f, input logic [3:0] p);
      if (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, p, f, va, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   // register writes on successive edges, block idle
   task automatic write_regs(input logic [2:0] idx [], input logic [51:0] val []);
      drain();
      foreach (idx[i]) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed requests around a few slots, the rest noise
   task automatic random_reqs(input int count);
      logic [1:0]  cmd;
      logic [63:0] va;
      logic [51:0] f;
      logic [3:0]  p;
      int          slot;
      for (int n = 0; n < count; n++) begin
         cmd = 2'($urandom_range(3));
         if ($urandom_range(99) < 75) begin
            slot = ($urandom_range(3) == 0) ? int'($urandom_range(511))
                                            : int'($urandom_range(15));
            va   = cur_base + (64'(slot) << 12);
            if ($urandom_range(7) != 0) f = 52'($urandom_range(1, 16)) << 12;
            else f = 52'({$urandom, $urandom}) & cur_mask;
            case ($urandom_range(4))
               0: p = 4'b1001;
               1: p = 4'b1011;
               2: p = 4'b1101;
               3: p = 4'b1111;
               default: p = 4'($urandom);
            endcase
         end else begin
            va = {$urandom, $urandom};
            if ($urandom_range(1)) va[63:48] = {16{va[47]}};
            f  = 52'({$urandom, $urandom});
            p  = 4'($urandom);
         end
         send_req(cmd, va, f, p);
      end
   endtask

   initial begin
      logic [63:0] w;
      w = 64'h20_0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed requests under reset settings
      send_req(CMD_MAP,   w + 64'h1000, 52'h1000, 4'b1001);
      send_req(CMD_QUERY, w + 64'h1000, 52'h0,    4'b0000);
      send_req(CMD_PERM,  w + 64'h1000, 52'h0,    4'b1111);  // write with execute
      send_req(CMD_PERM,  w + 64'h1000, 52'h0,    4'b1011);
      send_req(CMD_QUERY, w + 64'h1000, 52'hF_FFFF_FFFF_FFFF, 4'b1111);
      send_req(CMD_MAP,   w + 64'h2000, 52'h1000, 4'b1001);  // frame in use
      send_req(CMD_MAP,   w + 64'h1000, 52'h2000, 4'b1001);  // slot taken
      send_req(CMD_MAP,   w + 64'h2000, 52'h0,    4'b1001);
      send_req(CMD_MAP,   w + 64'h2000, 52'h1001, 4'b1001);
      send_req(CMD_MAP,   w + 64'h3000, 52'hF_FFFF_FFFF_F000, 4'b1101);
      send_req(CMD_MAP,   w + 64'h4000, 52'h5000, 4'b0000);
      send_req(CMD_MAP,   w,            52'h6000, 4'b1111);
      send_req(CMD_UNMAP, w + 64'h1000, 52'h2000, 4'b0000);  // wrong frame
      send_req(CMD_UNMAP, w + 64'h1000, 52'h1000, 4'b1111);
      send_req(CMD_UNMAP, w + 64'h1000, 52'h1000, 4'b0000);  // gone
      send_req(CMD_UNMAP, w + 64'h3000, 52'h0,    4'b0000);
      send_req(CMD_QUERY, w + 64'h5000, 52'h0,    4'b0000);
      send_req(CMD_QUERY, 64'h8000_0000_0000_0000, 52'h0, 4'b0000);
      send_req(CMD_QUERY, 64'h0000_8000_0000_0000, 52'h0, 4'b0000);
      send_req(CMD_QUERY, 64'hFFFF_8000_0000_0000, 52'h0, 4'b0000);
      send_req(CMD_QUERY, w + 64'h1,    52'h0,    4'b0000);
      send_req(CMD_QUERY, 64'h0,        52'h0,    4'b0000);
      send_req(CMD_MAP,   w - 64'h1000, 52'h7000, 4'b1001);
      send_req(CMD_MAP,   w + 64'h20_0000, 52'h7000, 4'b1001);
      send_req(CMD_MAP,   64'h3F_F000,  52'h7000, 4'b1001);  // guard page
      random_reqs(110);

      // small mask, private frames in the pool, guard outside, tight limit
      write_regs('{CSR_PHYS_MASK, CSR_PRIV_A, CSR_PRIV_B, CSR_PRIV_C, CSR_PRIV_D,
                   CSR_WIN_BASE, CSR_GUARD, CSR_LIMIT},
                 '{52'hF_F000, 52'h1000, 52'h2000, 52'h3000, 52'h4000,
                   52'h4000_0000, 52'h0, 52'd3});
      cur_base = 64'h4000_0000;
      cur_mask = 52'hF_F000;
      random_reqs(40);
      calm = 1'b1;
      random_reqs(60);
      calm = 1'b0;
      random_reqs(40);

      // one-frame mask, window at the top, guard at the top page, no mappings
      write_regs('{CSR_PHYS_MASK, CSR_WIN_BASE, CSR_GUARD, CSR_LIMIT},
                 '{52'h1000, 52'h7FFF_FFE0_0000, 52'h7FFF_FFFF_F000, 52'd0});
      cur_base = 64'h7FFF_FFE0_0000;
      cur_mask = 52'h1000;
      random_reqs(100);

      // full mask, window at zero, guard inside, limit back to the maximum
      write_regs('{CSR_PHYS_MASK, CSR_PRIV_A, CSR_PRIV_B, CSR_PRIV_C, CSR_PRIV_D,
                   CSR_WIN_BASE, CSR_GUARD, CSR_LIMIT},
                 '{52'hF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 52'h0, 52'h0, 52'h0,
                   52'h0, 52'h5000, 52'd512});
      cur_base = 64'h0;
      cur_mask = 52'hF_FFFF_FFFF_F000;
      random_reqs(175);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
